[hw/rtl/fhd_pkg.sv]
// Shared constants, result codes and the queue entry type for the frame header deframer.
// Has no dependencies. The parser, the result queue and the top level import it.
package fhd_pkg;

    localparam int HEADER_BYTES = 16;

    // Byte positions within the header
    localparam logic [3:0] HDR_POS_MAGIC_0 = 4'd0;
    localparam logic [3:0] HDR_POS_MAGIC_1 = 4'd1;
    localparam logic [3:0] HDR_POS_VERSION = 4'd2;
    localparam logic [3:0] HDR_POS_TYPE    = 4'd3;
    localparam logic [3:0] HDR_POS_ID_LO   = 4'd4;
    localparam logic [3:0] HDR_POS_ID_HI   = 4'd11;
    localparam logic [3:0] HDR_POS_LEN_LO  = 4'd12;
    localparam logic [3:0] HDR_POS_LAST    = 4'd15;

    localparam logic [7:0] MAGIC_0 = 8'h56;   // 'V'
    localparam logic [7:0] MAGIC_1 = 8'h53;   // 'S'

    // Known frame types
    localparam logic [7:0] TYPE_BASIC_MIN = 8'd1;
    localparam logic [7:0] TYPE_BASIC_MAX = 8'd7;
    localparam logic [7:0] TYPE_EXT_0     = 8'd64;
    localparam logic [7:0] TYPE_EXT_1     = 8'd65;
    localparam logic [7:0] TYPE_EXT_2     = 8'd66;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE     = 3'd4;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd5;

    // Configuration register indexes and reset values
    localparam int         CFG_INDEX_W           = 1;
    localparam logic [0:0] REG_PROTOCOL_VERSION  = 1'b0;
    localparam logic [0:0] REG_MAX_FRAME_BYTES   = 1'b1;
    localparam logic [7:0]  PROTOCOL_VERSION_RST = 8'd1;
    localparam logic [31:0] MAX_FRAME_BYTES_RST  = 32'd16777216;

    // Result queue sizing: one entry per processed byte that yields results
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = 2;
    localparam int QUEUE_CNT_W      = 3;
    localparam int QUEUE_ROOM_LIMIT = QUEUE_DEPTH - 2;

    // Up to two results per byte: a header or payload result, then a status
    typedef struct packed {
        logic        has_first;
        logic [1:0]  first_kind;
        logic [7:0]  frame_kind;
        logic [63:0] request_tag;
        logic [31:0] body_length;
        logic [7:0]  body_byte;
        logic        has_status;
        logic [2:0]  status;
    } frame_entry_t;

    function automatic logic type_is_known(input logic [7:0] t);
        return t inside {[TYPE_BASIC_MIN:TYPE_BASIC_MAX], TYPE_EXT_0, TYPE_EXT_1, TYPE_EXT_2};
    endfunction

endpackage

[hw/rtl/fhd_parse.sv]
// Input register and header parser: checks the header, gathers id and length, judges status.
// Depends on fhd_pkg.
module fhd_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           wire_byte,
    input  logic                 frame_end,
    input  logic [7:0]           protocol_version,
    input  logic [31:0]          max_frame_bytes,
    output logic                 push,
    output fhd_pkg::frame_entry_t push_entry
);
    import fhd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    logic [31:0] byte_count_reg, byte_count_next;
    logic [63:0] id_reg, id_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [2:0]  herr_reg, herr_next;

    logic        in_header;
    logic [3:0]  hdr_idx;
    logic [2:0]  id_sel;
    logic [1:0]  len_sel;
    logic [2:0]  err;
    logic        header_hit;
    logic        payload_hit;
    logic [31:0] body_size;
    logic [2:0]  frame_status;

    assign in_header = byte_count_reg < 32'(HEADER_BYTES);
    assign hdr_idx   = byte_count_reg[3:0];
    assign id_sel    = 3'(hdr_idx - HDR_POS_ID_LO);
    assign len_sel   = hdr_idx[1:0];

    assign byte_count_next = (byte_count_reg == 32'hFFFF_FFFF) ? byte_count_reg
                                                               : byte_count_reg + 32'd1;

    always_comb
    begin
        err       = ST_OK;
        type_next = type_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        if (in_header)
        begin
            case (hdr_idx) inside
                HDR_POS_MAGIC_0:
                    if (in_byte_reg != MAGIC_0) err = ST_BAD_MAGIC;
                HDR_POS_MAGIC_1:
                    if (in_byte_reg != MAGIC_1) err = ST_BAD_MAGIC;
                HDR_POS_VERSION:
                    if (in_byte_reg != protocol_version) err = ST_BAD_VERSION;
                HDR_POS_TYPE:
                begin
                    type_next = in_byte_reg;
                    if (!type_is_known(in_byte_reg)) err = ST_BAD_TYPE;
                end
                [HDR_POS_ID_LO:HDR_POS_ID_HI]:
                    id_next = id_reg | ({56'd0, in_byte_reg} << {id_sel, 3'b000});
                default:
                    len_next = len_reg | ({24'd0, in_byte_reg} << {len_sel, 3'b000});
            endcase
        end
    end

    assign herr_next   = (herr_reg == ST_OK) ? err : herr_reg;
    assign header_hit  = in_header && (hdr_idx == HDR_POS_LAST) && (herr_next == ST_OK);
    assign payload_hit = !in_header && (herr_reg == ST_OK);
    assign body_size   = byte_count_next - 32'(HEADER_BYTES);

    // Size beats header error beats length mismatch
    always_comb
    begin
        if (byte_count_next < 32'(HEADER_BYTES) || byte_count_next > max_frame_bytes)
            frame_status = ST_BAD_SIZE;
        else if (herr_next != ST_OK)
            frame_status = herr_next;
        else if (len_next != body_size)
            frame_status = ST_LEN_MISMATCH;
        else
            frame_status = ST_OK;
    end

    always_comb
    begin
        push_entry             = '0;
        push_entry.has_first   = header_hit || payload_hit;
        push_entry.first_kind  = header_hit ? KIND_HEADER : KIND_PAYLOAD;
        push_entry.has_status  = in_end_reg;
        push_entry.status      = frame_status;
        if (header_hit)
        begin
            push_entry.frame_kind  = type_next;
            push_entry.request_tag = id_next;
            push_entry.body_length = len_next;
        end
        else
        begin
            push_entry.body_byte = in_byte_reg;
        end
    end

    assign push = in_valid_reg && (header_hit || payload_hit || in_end_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= wire_byte;
            in_end_reg  <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            id_reg         <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            herr_reg       <= ST_OK;
        end
        else if (in_valid_reg)
        begin
            if (in_end_reg)
            begin
                byte_count_reg <= '0;
                id_reg         <= '0;
                len_reg        <= '0;
                type_reg       <= '0;
                herr_reg       <= ST_OK;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                id_reg         <= id_next;
                len_reg        <= len_next;
                type_reg       <= type_next;
                herr_reg       <= herr_next;
            end
        end
    end

endmodule

[hw/rtl/fhd_result_queue.sv]
// Result queue: holds parsed entries and hands out one result per transfer.
// Depends on fhd_pkg.
module fhd_result_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fhd_pkg::frame_entry_t push_entry,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic [7:0]            frame_kind,
    output logic [63:0]           request_tag,
    output logic [31:0]           body_length,
    output logic [7:0]            body_byte,
    output logic [2:0]            status,
    output logic                  end_of_run
);
    import fhd_pkg::*;

    frame_entry_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   phase_reg;

    frame_entry_t head;
    logic         show_first;
    logic         transfer;
    logic         pop;

    assign head       = mem_reg[rd_ptr_reg];
    assign out_valid  = count_reg != '0;
    assign show_first = head.has_first && !phase_reg;
    assign transfer   = out_valid && !out_stall;
    assign pop        = transfer && !(show_first && head.has_status);
    assign room       = count_reg <= QUEUE_CNT_W'(QUEUE_ROOM_LIMIT);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_comb
    begin
        if (show_first)
        begin
            result_kind = head.first_kind;
            frame_kind  = head.frame_kind;
            request_tag = head.request_tag;
            body_length = head.body_length;
            body_byte   = head.body_byte;
            status      = ST_OK;
            end_of_run  = !head.has_status;
        end
        else
        begin
            result_kind = KIND_STATUS;
            frame_kind  = '0;
            request_tag = '0;
            body_length = '0;
            body_byte   = '0;
            status      = head.status;
            end_of_run  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            if (transfer)
                phase_reg <= !pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH)) || pop)
        else $error("result queue overflow");

    a_entry_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.has_first || push_entry.has_status))
        else $error("empty entry pushed");

    a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (count_reg != '0) && head.has_first && head.has_status)
        else $error("second-result phase without a two-result entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[hw/rtl/frame_header_deframer.sv]
// Deframer top level: config registers, fhd_parse and fhd_result_queue; uses fhd_pkg.
// A byte transfer is held in the parse input register, then its entry goes into the queue.
// Throughput: one byte per cycle unless stalled. A byte with two results holds the output
//   for both; the four-entry queue absorbs it; input stalls only above two queued entries.
// Reset (rst_n, async, active low) clears the frame state and the queue, and sets
//   protocol_version to 1 and max_frame_bytes to 16777216.
module frame_header_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [fhd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_wdata,
    // byte input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      wire_byte,
    input  logic                            frame_end,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [7:0]                      frame_kind,
    output logic [63:0]                     request_tag,
    output logic [31:0]                     body_length,
    output logic [7:0]                      body_byte,
    output logic [2:0]                      status,
    output logic                            end_of_run
);
    import fhd_pkg::*;

    logic [7:0]   protocol_version_reg;
    logic [31:0]  max_frame_bytes_reg;

    logic         take;
    logic         push;
    logic         room;
    frame_entry_t push_entry;

    // Configuration registers; to be written only while idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_version_reg <= PROTOCOL_VERSION_RST;
            max_frame_bytes_reg  <= MAX_FRAME_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROTOCOL_VERSION: protocol_version_reg <= cfg_wdata[7:0];
                REG_MAX_FRAME_BYTES:  max_frame_bytes_reg  <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // Stall comes from the registered queue count, so it never looks at in_valid.
    assign in_stall = !room;
    assign take     = in_valid && !in_stall;

    // Input register + header parse; one queue entry per byte that yields results.
    fhd_parse u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .wire_byte        (wire_byte),
        .frame_end        (frame_end),
        .protocol_version (protocol_version_reg),
        .max_frame_bytes  (max_frame_bytes_reg),
        .push             (push),
        .push_entry       (push_entry)
    );

    // Queue splits each entry into its header/payload result and its status result.
    fhd_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_entry  (push_entry),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .frame_kind  (frame_kind),
        .request_tag (request_tag),
        .body_length (body_length),
        .body_byte   (body_byte),
        .status      (status),
        .end_of_run  (end_of_run)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for frame_header_deframer: streams frames byte by byte,
// mirrors the header parse in a local predictor and checks every result transfer.
// Depends on fhd_pkg and the frame_header_deframer RTL; nothing else.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhd_pkg::*;

    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, fills the result queue
    localparam int DRAIN_CYCLES   = 8;     // margin for the block to go quiet
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int PHASE_BYTES    = 110;   // random bytes per configuration phase

    // One expected result, field for field as the block presents it
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ftype;
        logic [63:0] tag;
        logic [31:0] blen;
        logic [7:0]  bbyte;
        logic [2:0]  st;
        logic        last;
    } deframe_result_t;

    // Directed stimulus row; pin marks rows whose status is typed in by hand
    typedef struct packed {
        logic [7:0] b;
        logic       e;
        logic       pin;
        logic [2:0] st;
    } stim_row_t;

    typedef enum int {
        FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_TYPE,
        FLAW_LENGTH, FLAW_SHORT, FLAW_MIXED, FLAW_NOISE
    } frame_flaw_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             wire_byte;
    logic                   frame_end;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             result_kind;
    logic [7:0]             frame_kind;
    logic [63:0]            request_tag;
    logic [31:0]            body_length;
    logic [7:0]             body_byte;
    logic [2:0]             status;
    logic                   end_of_run;

    // Travels with each byte transfer: a status typed in by hand for that byte
    logic                   status_pinned;
    logic [2:0]             pinned_code;

    // Predictor state: register copies and the per-frame parse state
    logic [7:0]             want_version;
    logic [31:0]            want_max_bytes;
    logic [31:0]            rx_count;
    logic [63:0]            rx_tag;
    logic [31:0]            rx_length;
    logic [7:0]             rx_type;
    logic [2:0]             rx_error;

    deframe_result_t        pending_results[$];
    deframe_result_t        head;
    stim_row_t              directed_rows[21];

    int                     mismatches = 0;
    int                     bytes_sent = 0;
    int                     burst_left = 0;
    bit                     hold_req = 1'b0;
    bit                     hold_done = 1'b0;

    frame_header_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .wire_byte   (wire_byte),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .frame_kind  (frame_kind),
        .request_tag (request_tag),
        .body_length (body_length),
        .body_byte   (body_byte),
        .status      (status),
        .end_of_run  (end_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit frame_type_known(input logic [7:0] t);
        return t inside {[TYPE_BASIC_MIN:TYPE_BASIC_MAX], TYPE_EXT_0, TYPE_EXT_1, TYPE_EXT_2};
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input logic [7:0] ftype,
                                          input logic [63:0] tag, input logic [31:0] blen,
                                          input logic [7:0] bbyte, input logic [2:0] st,
                                          input logic last);
        deframe_result_t r;
        r.kind  = kind;
        r.ftype = ftype;
        r.tag   = tag;
        r.blen  = blen;
        r.bbyte = bbyte;
        r.st    = st;
        r.last  = last;
        pending_results = {pending_results, r};
    endfunction

    function automatic void clear_parse();
        rx_count  = '0;
        rx_tag    = '0;
        rx_length = '0;
        rx_type   = '0;
        rx_error  = ST_OK;
    endfunction

    // Parses one accepted byte and queues the results it must produce
    function automatic void deframe_byte(input logic [7:0] b, input logic last_byte,
                                         input logic pin, input logic [2:0] pinned);
        logic [31:0] pos;
        logic [2:0]  err;
        logic [2:0]  st;
        pos = rx_count;
        if (rx_count != 32'hFFFF_FFFF)
            rx_count = rx_count + 32'd1;

        if (pos < HEADER_BYTES)
        begin
            err = ST_OK;
            if (pos == HDR_POS_MAGIC_0 && b != MAGIC_0)
                err = ST_BAD_MAGIC;
            else if (pos == HDR_POS_MAGIC_1 && b != MAGIC_1)
                err = ST_BAD_MAGIC;
            else if (pos == HDR_POS_VERSION && b != want_version)
                err = ST_BAD_VERSION;
            else if (pos == HDR_POS_TYPE)
            begin
                rx_type = b;
                if (!frame_type_known(b))
                    err = ST_BAD_TYPE;
            end
            else if (pos >= HDR_POS_ID_LO && pos <= HDR_POS_ID_HI)
                rx_tag |= 64'(b) << (8 * (pos - HDR_POS_ID_LO));
            else if (pos >= HDR_POS_LEN_LO)
                rx_length |= 32'(b) << (8 * (pos - HDR_POS_LEN_LO));

            // only the first header error of a frame is kept
            if (err != ST_OK && rx_error == ST_OK)
                rx_error = err;
            if (pos == HDR_POS_LAST && rx_error == ST_OK)
                expect_result(KIND_HEADER, rx_type, rx_tag, rx_length, 8'd0, ST_OK,
                              !last_byte);
        end
        else if (rx_error == ST_OK)
            expect_result(KIND_PAYLOAD, 8'd0, 64'd0, 32'd0, b, ST_OK, !last_byte);

        if (last_byte)
        begin
            // size beats header errors, which beat a length mismatch
            if (rx_count < HEADER_BYTES || rx_count > want_max_bytes)
                st = ST_BAD_SIZE;
            else if (rx_error != ST_OK)
                st = rx_error;
            else if (rx_length != rx_count - HEADER_BYTES)
                st = ST_LEN_MISMATCH;
            else
                st = ST_OK;
            if (pin)
                st = pinned;
            expect_result(KIND_STATUS, 8'd0, 64'd0, 32'd0, 8'd0, st, 1'b1);
            clear_parse();
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register copies, prediction on byte transfers, checking on
    // result transfers. One process, so prediction always precedes checking.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROTOCOL_VERSION: want_version   = cfg_wdata[7:0];
                    REG_MAX_FRAME_BYTES:  want_max_bytes = cfg_wdata;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                deframe_byte(wire_byte, frame_end, status_pinned, pinned_code);

            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d status %0d",
                           result_kind, status);
                    mismatches++;
                end
                else
                begin
                    head = pending_results.pop_front();
                    compare_field("result_kind", head.kind, result_kind);
                    compare_field("frame_kind", head.ftype, frame_kind);
                    compare_field("request_tag", head.tag, request_tag);
                    compare_field("body_length", head.blen, body_length);
                    compare_field("body_byte", head.bbyte, body_byte);
                    compare_field("status", head.st, status);
                    compare_field("end_of_run", head.last, end_of_run);
                end
            end
        end
    end

    // Watchdog: ends the run if neither side moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                // sender keeps offering bytes meanwhile, so the input backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(4, 60);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;                          // free flow
                    1:       out_stall <= ($urandom_range(0, 3) == 0);   // light
                    2:       out_stall <= ($urandom_range(0, 1) == 0);   // heavy
                    default: out_stall <= (mode_left % 3 == 0);          // periodic
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one byte at the current falling edge, returns at the falling
    // edge after its transfer, possibly after an idle gap between bursts.
    task automatic send_byte(input logic [7:0] b, input logic e, input logic pin,
                             input logic [2:0] pinned);
        int gap;
        in_valid      <= 1'b1;
        wire_byte     <= b;
        frame_end     <= e;
        status_pinned <= pin;
        pinned_code   <= pinned;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Waits for every expected result, then for the pipeline to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] version, input logic [31:0] max_bytes);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROTOCOL_VERSION;
        cfg_wdata <= {24'd0, version};
        @(negedge clk);
        cfg_index <= REG_MAX_FRAME_BYTES;
        cfg_wdata <= max_bytes;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic frame_flaw_t pick_flaw();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return FLAW_NONE;
        if (roll < 58) return FLAW_MAGIC;
        if (roll < 66) return FLAW_VERSION;
        if (roll < 74) return FLAW_TYPE;
        if (roll < 84) return FLAW_LENGTH;
        if (roll < 92) return FLAW_SHORT;
        if (roll < 96) return FLAW_MIXED;
        return FLAW_NOISE;
    endfunction

    // Builds one frame, mostly well formed, and streams it out
    task automatic send_frame();
        logic [7:0]  fb[$];
        frame_flaw_t flaw;
        int          n_body;
        int          pick;
        int          cut;
        logic [63:0] tag;
        logic [31:0] declared;
        logic [7:0]  ftype;
        flaw   = pick_flaw();
        n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        tag    = {$urandom, $urandom};

        declared = 32'(n_body);
        if (flaw == FLAW_LENGTH)
        begin
            do
                declared = $urandom;
            while (declared == 32'(n_body));
        end

        if (flaw == FLAW_TYPE || flaw == FLAW_MIXED)
        begin
            do
                ftype = 8'($urandom);
            while (frame_type_known(ftype));
        end
        else
        begin
            pick  = $urandom_range(0, 9);
            ftype = (pick < 7) ? 8'(pick + 1) : TYPE_EXT_0 + 8'(pick - 7);
        end

        fb = {fb, MAGIC_0};
        fb = {fb, MAGIC_1};
        fb = {fb, want_version};
        fb = {fb, ftype};
        for (int i = 0; i < 8; i++)
            fb = {fb, tag[8*i +: 8]};
        for (int i = 0; i < 4; i++)
            fb = {fb, declared[8*i +: 8]};
        repeat (n_body) fb = {fb, 8'($urandom)};

        case (flaw)
            FLAW_MAGIC:   fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FLAW_VERSION: fb[HDR_POS_VERSION] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT:
            begin
                cut = $urandom_range(1, HEADER_BYTES - 1);
                while (fb.size() > cut)
                    void'(fb.pop_back());
            end
            FLAW_MIXED:
            begin
                // several header errors: the earliest one must be reported
                if ($urandom_range(0, 1) == 1)
                    fb[HDR_POS_MAGIC_1] ^= 8'($urandom_range(1, 255));
                fb[HDR_POS_VERSION] ^= 8'($urandom_range(1, 255));
            end
            FLAW_NOISE:
            begin
                fb.delete();
                repeat ($urandom_range(1, 24)) fb = {fb, 8'($urandom)};
            end
            default: ;
        endcase

        foreach (fb[i])
            send_byte(fb[i], i == fb.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic run_phase(input logic [7:0] version, input logic [31:0] max_bytes,
                             input bit with_holdoff);
        int first;
        configure(version, max_bytes);
        if (with_holdoff)
            hold_req = 1'b1;
        first = bytes_sent;
        while (bytes_sent - first < PHASE_BYTES)
            send_frame();
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_PROTOCOL_VERSION;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        wire_byte     = '0;
        frame_end     = 1'b0;
        status_pinned = 1'b0;
        pinned_code   = ST_OK;
        want_version   = PROTOCOL_VERSION_RST;
        want_max_bytes = MAX_FRAME_BYTES_RST;
        clear_parse();

        // Directed frames at reset settings:
        //   one wrong byte ending the frame (size error wins over magic),
        //   a three-byte frame with a good start (still a size error),
        //   a full header with all-ones id and type 66, one 0xFF payload byte.
        directed_rows = '{
            {8'h00,                1'b1, 1'b1, ST_BAD_SIZE},
            {MAGIC_0,              1'b0, 1'b0, ST_OK},
            {MAGIC_1,              1'b0, 1'b0, ST_OK},
            {8'h01,                1'b1, 1'b1, ST_BAD_SIZE},
            {MAGIC_0,              1'b0, 1'b0, ST_OK},
            {MAGIC_1,              1'b0, 1'b0, ST_OK},
            {PROTOCOL_VERSION_RST, 1'b0, 1'b0, ST_OK},
            {TYPE_EXT_2,           1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b0, 1'b0, ST_OK},
            {8'h01,                1'b0, 1'b0, ST_OK},
            {8'h00,                1'b0, 1'b0, ST_OK},
            {8'h00,                1'b0, 1'b0, ST_OK},
            {8'h00,                1'b0, 1'b0, ST_OK},
            {8'hFF,                1'b1, 1'b1, ST_OK}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].e, directed_rows[i].pin,
                      directed_rows[i].st);
        settle();

        // Register extremes first, then a tight size limit, then back to reset values
        run_phase(8'h00, 32'hFFFF_FFFF, 1'b1);
        run_phase(8'hFF, 32'd16, 1'b0);
        run_phase(8'($urandom_range(2, 254)), 32'($urandom_range(17, 28)), 1'b0);
        run_phase(PROTOCOL_VERSION_RST, MAX_FRAME_BYTES_RST, 1'b0);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/fhd_pkg.sv
hw/rtl/fhd_parse.sv
hw/rtl/fhd_result_queue.sv
hw/rtl/frame_header_deframer.sv
tb/tb.sv
